### hw/rtl/mst_pkg.sv
// Shared constants, codes and types of the multi-slot compare timer.
`default_nettype none

package mst_pkg;

   localparam int NUM_SLOTS  = 4;
   localparam int COUNT_BITS = 24;

   // Field widths of the request and response channels.
   localparam int FUNC_BITS   = 2;
   localparam int SLOT_BITS   = 2;
   localparam int PERIOD_BITS = 24;
   localparam int STATUS_BITS = 2;
   localparam int FIRED_BITS  = 4;

   localparam int IDX_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int ACT_BITS = $clog2(NUM_SLOTS + 1);

   localparam logic [31:0] COUNT_MASK = 32'((64'd1 << COUNT_BITS) - 64'd1);

   typedef enum logic [FUNC_BITS-1:0] {
      FN_CREATE = 2'd0,
      FN_START  = 2'd1,
      FN_STOP   = 2'd2,
      FN_TICK   = 2'd3
   } func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK       = 2'd0,
      ST_INVALID  = 2'd1,
      ST_NO_SPACE = 2'd2,
      ST_ALREADY  = 2'd3
   } status_type;

endpackage

`default_nettype wire

### hw/rtl/mst_req_if.sv
// Request channel of the multi-slot compare timer: valid, ready and one command.
`default_nettype none

interface mst_req_if import mst_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [FUNC_BITS-1:0]   func;
   logic [SLOT_BITS-1:0]   slot;
   logic                   repeat_req;
   logic [PERIOD_BITS-1:0] period_us;

   modport source (output valid, output func, output slot, output repeat_req,
                   output period_us, input ready);
   modport sink (input valid, input func, input slot, input repeat_req,
                 input period_us, output ready);
endinterface

`default_nettype wire

### hw/rtl/mst_rsp_if.sv
// Response channel of the multi-slot compare timer: valid, ready and one result.
`default_nettype none

interface mst_rsp_if import mst_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [SLOT_BITS-1:0]   slot_id;
   logic [FIRED_BITS-1:0]  fired_mask;
   logic                   running;

   modport source (output valid, output status, output slot_id, output fired_mask,
                   output running, input ready);
   modport sink (input valid, input status, input slot_id, input fired_mask,
                 input running, output ready);
endinterface

`default_nettype wire

### hw/rtl/mst_add_cmp.sv
// Shared modulo adder and equality compare used by start, tick and the slot scan of the sequencer.
`default_nettype none

module mst_add_cmp import mst_pkg::*; (
   input  wire logic [COUNT_BITS-1:0] add_a,
   input  wire logic [COUNT_BITS-1:0] add_b,
   input  wire logic [COUNT_BITS-1:0] cmp_c,
   output logic      [COUNT_BITS-1:0] sum,
   output logic                       equal
);

   // The sum wraps at the counter width, which is the modulo of the timer.
   assign sum   = add_a + add_b;
   assign equal = (add_a == cmp_c);

endmodule

`default_nettype wire

### hw/rtl/multi_slot_compare_timer.sv
// Top level of the multi-slot compare timer: command sequencer and slot state.
//
//   channel   direction  transfer moves
//   req_chan  in         func, slot, repeat_req, period_us
//   rsp_chan  out        status, slot_id, fired_mask, running
//
// Create, start and stop pass from transfer through S_EXEC and S_DONE to the response.
// A tick with an armed slot also passes through S_SCAN, since the one adder and comparator
// visit the slots in turn, and a tick with no armed slot goes from S_EXEC to S_DONE.
// req_chan is ready only while the sequencer is idle, one command at a time.
// A finished response waits in the output register; a stalled rsp_chan holds the
// next result in the sequencer until the register frees up.
// Synchronous reset frees all slots and clears the shared counter.
`default_nettype none

module multi_slot_compare_timer import mst_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   mst_req_if.sink   req_chan,
   mst_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [NUM_SLOTS-1:0]  alloc_ff, alloc_in;
   logic [NUM_SLOTS-1:0]  active_ff, active_in;
   logic [NUM_SLOTS-1:0]  repeating_ff, repeating_in;
   logic [COUNT_BITS-1:0] period_ff [NUM_SLOTS];
   logic [COUNT_BITS-1:0] period_in [NUM_SLOTS];
   logic [COUNT_BITS-1:0] deadline_ff [NUM_SLOTS];
   logic [COUNT_BITS-1:0] deadline_in [NUM_SLOTS];
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [ACT_BITS-1:0]   act_cnt_ff, act_cnt_in;

   // Latched command.
   func_type              func_ff, func_in;
   logic [SLOT_BITS-1:0]  slot_ff, slot_in;
   logic                  rep_ff, rep_in;
   logic [COUNT_BITS-1:0] per_ff, per_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;

   // Result under construction.
   status_type            status_ff, status_in;
   logic [SLOT_BITS-1:0]  sid_ff, sid_in;
   logic [NUM_SLOTS-1:0]  fired_ff, fired_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [SLOT_BITS-1:0]  rsp_sid_ff, rsp_sid_in;
   logic [NUM_SLOTS-1:0]  rsp_fired_ff, rsp_fired_in;
   logic                  rsp_running_ff, rsp_running_in;

   logic [COUNT_BITS-1:0] alu_b;
   logic [COUNT_BITS-1:0] alu_sum;
   logic                  alu_eq;

   logic                  free_found;
   logic [IDX_BITS-1:0]   free_idx;
   logic [IDX_BITS-1:0]   slot_idx;
   logic                  slot_ok;
   logic [31:0]           per_wide;

   mst_add_cmp u_add_cmp (
      .add_a (count_ff),
      .add_b (alu_b),
      .cmp_c (deadline_ff[idx_ff]),
      .sum   (alu_sum),
      .equal (alu_eq)
   );

   // Lowest free slot for create.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!alloc_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_BITS'(i);
         end
      end
   end

   assign slot_idx = IDX_BITS'(slot_ff);
   assign slot_ok  = (32'(slot_ff) < NUM_SLOTS) && alloc_ff[slot_idx];
   assign per_wide = 32'(req_chan.period_us);

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.slot_id    = rsp_sid_ff;
   assign rsp_chan.fired_mask = FIRED_BITS'(rsp_fired_ff);
   assign rsp_chan.running    = rsp_running_ff;

   always_comb begin
      state_in       = state_ff;
      alloc_in       = alloc_ff;
      active_in      = active_ff;
      repeating_in   = repeating_ff;
      period_in      = period_ff;
      deadline_in    = deadline_ff;
      count_in       = count_ff;
      act_cnt_in     = act_cnt_ff;
      func_in        = func_ff;
      slot_in        = slot_ff;
      rep_in         = rep_ff;
      per_in         = per_ff;
      idx_in         = idx_ff;
      status_in      = status_ff;
      sid_in         = sid_ff;
      fired_in       = fired_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_sid_in     = rsp_sid_ff;
      rsp_fired_in   = rsp_fired_ff;
      rsp_running_in = rsp_running_ff;
      alu_b          = per_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               func_in = func_type'(req_chan.func);
               slot_in = req_chan.slot;
               rep_in  = req_chan.repeat_req;
               // Periods beyond the counter range saturate.
               per_in  = (per_wide > COUNT_MASK) ? COUNT_MASK[COUNT_BITS-1:0]
                                                 : COUNT_BITS'(per_wide);
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = ST_OK;
            sid_in    = '0;
            fired_in  = '0;
            state_in  = S_DONE;
            unique case (func_ff)
               FN_CREATE: begin
                  if (free_found) begin
                     alloc_in[free_idx]     = 1'b1;
                     active_in[free_idx]    = 1'b0;
                     repeating_in[free_idx] = rep_ff;
                     sid_in                 = SLOT_BITS'(free_idx);
                  end else begin
                     status_in = ST_NO_SPACE;
                  end
               end
               FN_START: begin
                  if (!slot_ok) begin
                     status_in = ST_INVALID;
                  end else if (active_ff[slot_idx]) begin
                     status_in = ST_ALREADY;
                  end else begin
                     period_in[slot_idx]   = per_ff;
                     deadline_in[slot_idx] = alu_sum;
                     active_in[slot_idx]   = 1'b1;
                     act_cnt_in            = act_cnt_ff + ACT_BITS'(1);
                  end
               end
               FN_STOP: begin
                  if (!slot_ok) begin
                     status_in = ST_INVALID;
                  end else if (active_ff[slot_idx]) begin
                     active_in[slot_idx] = 1'b0;
                     act_cnt_in          = act_cnt_ff - ACT_BITS'(1);
                  end
               end
               FN_TICK: begin
                  if (act_cnt_ff != '0) begin
                     alu_b    = COUNT_BITS'(1);
                     count_in = alu_sum;
                     idx_in   = '0;
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SCAN: begin
            // One slot per cycle: compare its deadline and compute its reload.
            alu_b = period_ff[idx_ff];
            if (active_ff[idx_ff] && alu_eq) begin
               fired_in[idx_ff] = 1'b1;
               if (repeating_ff[idx_ff]) begin
                  deadline_in[idx_ff] = alu_sum;
               end else begin
                  active_in[idx_ff] = 1'b0;
                  act_cnt_in        = act_cnt_ff - ACT_BITS'(1);
               end
            end
            if (idx_ff == IDX_BITS'(NUM_SLOTS - 1)) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + IDX_BITS'(1);
            end
         end
         S_DONE: begin
            // The counter halts and clears once no slot is armed.
            if (act_cnt_ff == '0) begin
               count_in = '0;
            end
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_sid_in     = sid_ff;
               rsp_fired_in   = fired_ff;
               rsp_running_in = (act_cnt_ff != '0);
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         alloc_ff     <= '0;
         active_ff    <= '0;
         repeating_ff <= '0;
         count_ff     <= '0;
         act_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alloc_ff     <= alloc_in;
         active_ff    <= active_in;
         repeating_ff <= repeating_in;
         count_ff     <= count_in;
         act_cnt_ff   <= act_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      period_ff      <= period_in;
      deadline_ff    <= deadline_in;
      func_ff        <= func_in;
      slot_ff        <= slot_in;
      rep_ff         <= rep_in;
      per_ff         <= per_in;
      idx_ff         <= idx_in;
      status_ff      <= status_in;
      sid_ff         <= sid_in;
      fired_ff       <= fired_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_sid_ff     <= rsp_sid_in;
      rsp_fired_ff   <= rsp_fired_in;
      rsp_running_ff <= rsp_running_in;
   end

   // The active count always matches the armed slots.
   a_act_count : assert property (@(posedge clock) disable iff (reset)
      32'(act_cnt_ff) == $countones(active_ff))
      else $error("active slot count disagrees with armed slots");

   // Only allocated slots can be armed.
   a_active_alloc : assert property (@(posedge clock) disable iff (reset)
      (active_ff & ~alloc_ff) == '0)
      else $error("armed slot is not allocated");

   // An idle timer with no armed slot has a cleared counter.
   a_count_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && act_cnt_ff == '0) |-> (count_ff == '0))
      else $error("shared counter runs with no armed slot");

   // A command transfer starts execution in the next cycle.
   a_accept_exec : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == S_EXEC))
      else $error("accepted command did not start execution");

   // Fired slots are reported only for ticks.
   a_fired_tick : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && func_ff != FN_TICK) |-> (fired_ff == '0))
      else $error("non-tick command reports fired slots");

endmodule

`default_nettype wire
